FILE: design/qob_pkg.sv
// ============================================================================
// qob_pkg: shared types and constants for the quadrature oscillator bank
// Request and result structs, sequencer codes, fixed-point limits, saturation.
// ============================================================================
package qob_pkg;

  localparam int MAX_PARTIALS_DEF = 64;

  // Shared multiplier: 27 x 27 signed covers every operand pair
  localparam int OP_W   = 27;
  localparam int PROD_W = 2 * OP_W;
  localparam int E_W    = 26;   // effective step, unsigned Q3.23
  localparam int SAMP_W = 26;   // scaled sample, signed Q3.22
  localparam int ACC_W  = 40;
  localparam int SUM_W  = 32;

  localparam logic CMD_PROC = 1'b0;
  localparam logic CMD_LOAD = 1'b1;

  localparam logic [23:0]        SMOOTH_RST = 24'd16777;
  localparam logic signed [23:0] COS_RST    = 24'sh400000;

  localparam logic signed [PROD_W-1:0] HALF_22 = PROD_W'(1) << 21;
  localparam logic signed [PROD_W-1:0] HALF_23 = PROD_W'(1) << 22;
  localparam logic signed [PROD_W-1:0] HALF_24 = PROD_W'(1) << 23;
  localparam logic signed [PROD_W-1:0] AMP_MAX = PROD_W'(24'hFFFFFF);

  typedef struct packed {
    logic               cmd;
    logic [5:0]         partial;
    logic [23:0]        step_size;
    logic [23:0]        detune;
    logic [23:0]        target_amp;
    logic [23:0]        alias_gain;
    logic [23:0]        pan_left;
    logic [23:0]        pan_right;
    logic               last_partial;
    logic signed [23:0] init_sine;
    logic signed [23:0] init_cosine;
    logic [23:0]        init_amp;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sum_left;
    logic signed [31:0] sum_right;
  } out_item_t;

  typedef struct packed {
    logic signed [23:0] sine;
    logic signed [23:0] cosine;
    logic [23:0]        amp;
  } osc_t;

  localparam osc_t OSC_RST = '{sine: 24'sd0, cosine: COS_RST, amp: 24'd0};

  typedef enum logic [3:0] {
    ST_IDLE, ST_TGT, ST_STEP, ST_SMOOTH, ST_SIN, ST_SAMP,
    ST_COS, ST_PANL, ST_PANR, ST_DONE, ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_TGT, MUL_STEP, MUL_SMOOTH, MUL_SIN,
    MUL_SAMP, MUL_COS, MUL_PANL, MUL_PANR
  } mul_op_t;

  typedef enum logic [3:0] {
    POST_NONE, POST_TGT, POST_STEP, POST_SMOOTH, POST_SIN,
    POST_SAMP, POST_COS, POST_PANL, POST_PANR
  } post_op_t;

  typedef struct packed {
    logic     busy;
    mul_op_t  mul_op;
    post_op_t post_op;
    logic     capture;
    logic     wr_back;
    logic     emit;
  } ctl_t;

  function automatic logic signed [23:0] sat24(input logic signed [29:0] v);
    if (v > 30'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -30'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat40(input logic signed [ACC_W:0] v);
    if (v > 41'sd549755813887) begin
      return 40'sh7F_FFFF_FFFF;
    end else if (v < -41'sd549755813888) begin
      return 40'sh80_0000_0000;
    end
    return v[ACC_W-1:0];
  endfunction

  function automatic logic signed [SUM_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    if (v > 40'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[SUM_W-1:0];
  endfunction

endpackage

FILE: design/quadrature_oscillator_bank_top.sv
// ============================================================================
// quadrature_oscillator_bank_top: magic-circle oscillator bank
// Smooths, scales, pans and advances one partial per request on a single
// shared multiplier; emits the saturated left/right mix at each frame end.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall / in_data): one request per partial.
//   A process request (cmd 0) for a partial in range holds in_stall through
//   the sequencer states TGT to DONE after it is taken: the shared multiplier
//   runs eight products back to back, and the DONE state closes the right
//   accumulator and writes the oscillator back. A load request (cmd 1) or a
//   process request for a partial out of range does not start the sequence.
//   A process request marked last_partial adds the EMIT state, which waits for
//   a free result register and then loads the result into it.
//   Result channel (out_valid / out_stall / out_data): one result per frame.
//   The result sits in an output register; while the receiver stalls, the
//   block keeps taking requests and holds in_stall only when the next frame
//   end arrives before the previous result has been taken.
//   cfg_we / cfg_data write the smoothing coefficient; the user must do so
//   only while the block is idle, as the block does not enforce it.
//   Reset (rst_n low, synchronous) drops any pending result, clears both
//   accumulators, restores the coefficient and marks every partial as the
//   reset oscillator (sine 0, cosine 1.0, amplitude 0) at once; no sweep.
// ============================================================================
module quadrature_oscillator_bank_top #(
  parameter int MAX_PARTIALS = qob_pkg::MAX_PARTIALS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [23:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  qob_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output qob_pkg::out_item_t out_data
);
  import qob_pkg::*;

  localparam int IDX_W = (MAX_PARTIALS > 1) ? $clog2(MAX_PARTIALS) : 1;

  ctl_t ctl;

  // request side
  logic             in_accept;
  logic             in_range;
  logic [IDX_W-1:0] in_addr;
  in_item_t         item_r;
  logic [IDX_W-1:0] item_addr;

  // configuration
  logic [23:0] smooth_coeff_r;
  logic [23:0] smooth_coeff_nxt;

  // store ports
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  osc_t             wr_data;
  osc_t             rd_osc;

  // shared multiplier
  logic signed [OP_W-1:0]   op_a;
  logic signed [OP_W-1:0]   op_b;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] rnd22;
  logic signed [PROD_W-1:0] rnd23;
  logic signed [PROD_W-1:0] rnd24;
  logic signed [24:0]       amp_diff;

  // working registers
  logic [23:0]              tgt_r, tgt_nxt;
  logic [E_W-1:0]           e_r, e_nxt;
  logic [23:0]              amp_r, amp_nxt;
  logic signed [23:0]       s_r, s_nxt;
  logic signed [23:0]       c_r, c_nxt;
  logic signed [23:0]       sn_r, sn_nxt;
  logic signed [23:0]       cn_r, cn_nxt;
  logic signed [SAMP_W-1:0] samp_r, samp_nxt;
  logic signed [ACC_W-1:0]  acc_left_r, acc_left_nxt;
  logic signed [ACC_W-1:0]  acc_right_r, acc_right_nxt;

  logic signed [25:0]      amp_sum;
  logic signed [29:0]      sin_sum;
  logic signed [29:0]      cos_diff;
  logic signed [ACC_W:0]   acc_left_sum;
  logic signed [ACC_W:0]   acc_right_sum;

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // ---------------------------------------------------------------- request
  assign in_stall  = ctl.busy;
  assign in_accept = in_valid && !in_stall;
  assign in_range  = 32'(in_data.partial) < MAX_PARTIALS;
  assign in_addr   = IDX_W'(in_data.partial);
  assign item_addr = IDX_W'(item_r.partial);

  // hold the request fields for the whole sequence
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
  end

  // ---------------------------------------------------------- configuration
  assign smooth_coeff_nxt = cfg_we ? cfg_data : smooth_coeff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_coeff_r <= SMOOTH_RST;
    end else begin
      smooth_coeff_r <= smooth_coeff_nxt;
    end
  end

  // -------------------------------------------------------------- sequencer
  qob_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_data.cmd),
    .in_last   (in_data.last_partial),
    .in_range  (in_range),
    .item_last (item_r.last_partial),
    .out_valid (out_valid_r),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  // ---------------------------------------------------------- oscillator store
  // Read on a process request; write on a load request or at write-back.
  // The two writes never share a cycle: write-back happens while busy.
  assign rd_en   = in_accept && in_data.cmd == CMD_PROC && in_range;
  assign wr_en   = ctl.wr_back || (in_accept && in_data.cmd == CMD_LOAD && in_range);
  assign wr_addr = ctl.wr_back ? item_addr : in_addr;

  always_comb begin
    if (ctl.wr_back) begin
      wr_data.sine   = sn_r;
      wr_data.cosine = cn_r;
      wr_data.amp    = amp_r;
    end else begin
      wr_data.sine   = in_data.init_sine;
      wr_data.cosine = in_data.init_cosine;
      wr_data.amp    = in_data.init_amp;
    end
  end

  qob_store #(
    .DEPTH (MAX_PARTIALS),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (in_addr),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_osc)
  );

  // -------------------------------------------------------- multiplier feed
  // Schedule: each product is registered in prod_r and rounded into its working
  // register in the following state, so a dependent product is issued only once
  // its source has passed through both prod_r and the working register.
  assign amp_diff = $signed({1'b0, tgt_r}) - $signed({1'b0, amp_r});

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (ctl.mul_op)
      MUL_TGT: begin
        op_a = $signed({3'b000, item_r.target_amp});
        op_b = $signed({3'b000, item_r.alias_gain});
      end
      MUL_STEP: begin
        op_a = $signed({3'b000, item_r.step_size});
        op_b = $signed({3'b000, item_r.detune});
      end
      MUL_SMOOTH: begin
        op_a = $signed({3'b000, smooth_coeff_r});
        op_b = OP_W'(amp_diff);
      end
      MUL_SIN: begin
        op_a = $signed({1'b0, e_r});
        op_b = OP_W'(c_r);
      end
      MUL_SAMP: begin
        op_a = OP_W'(s_r);
        op_b = $signed({3'b000, amp_r});
      end
      MUL_COS: begin
        op_a = $signed({1'b0, e_r});
        op_b = OP_W'(sn_r);
      end
      MUL_PANL: begin
        op_a = OP_W'(samp_r);
        op_b = $signed({3'b000, item_r.pan_left});
      end
      MUL_PANR: begin
        op_a = OP_W'(samp_r);
        op_b = $signed({3'b000, item_r.pan_right});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  qob_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // ------------------------------------------------------ rounding and update
  // Round half up: add half an LSB, then floor by arithmetic shift.
  assign rnd22 = (prod_r + HALF_22) >>> 22;
  assign rnd23 = (prod_r + HALF_23) >>> 23;
  assign rnd24 = (prod_r + HALF_24) >>> 24;

  assign amp_sum       = $signed({2'b00, amp_r}) + $signed(rnd24[25:0]);
  assign sin_sum       = 30'(s_r) + $signed(rnd23[29:0]);
  assign cos_diff      = 30'(c_r) - $signed(rnd23[29:0]);
  assign acc_left_sum  = (ACC_W + 1)'(acc_left_r) + $signed(rnd23[ACC_W:0]);
  assign acc_right_sum = (ACC_W + 1)'(acc_right_r) + $signed(rnd23[ACC_W:0]);

  always_comb begin
    tgt_nxt       = tgt_r;
    e_nxt         = e_r;
    amp_nxt       = amp_r;
    s_nxt         = s_r;
    c_nxt         = c_r;
    sn_nxt        = sn_r;
    cn_nxt        = cn_r;
    samp_nxt      = samp_r;
    acc_left_nxt  = acc_left_r;
    acc_right_nxt = acc_right_r;

    // load the stored oscillator for this partial
    if (ctl.capture) begin
      s_nxt   = rd_osc.sine;
      c_nxt   = rd_osc.cosine;
      amp_nxt = rd_osc.amp;
    end

    unique case (ctl.post_op)
      POST_TGT: begin
        // target times gain, clipped to the amplitude range
        tgt_nxt = (rnd23 > AMP_MAX) ? 24'hFFFFFF : rnd23[23:0];
      end
      POST_STEP: begin
        e_nxt = rnd22[E_W-1:0];
      end
      POST_SMOOTH: begin
        // new amplitude lies between old and target: no clip needed
        amp_nxt = amp_sum[23:0];
      end
      POST_SIN: begin
        sn_nxt = sat24(sin_sum);
      end
      POST_SAMP: begin
        samp_nxt = rnd23[SAMP_W-1:0];
      end
      POST_COS: begin
        cn_nxt = sat24(cos_diff);
      end
      POST_PANL: begin
        acc_left_nxt = sat40(acc_left_sum);
      end
      POST_PANR: begin
        acc_right_nxt = sat40(acc_right_sum);
      end
      default: begin
        tgt_nxt = tgt_r;
      end
    endcase

    // frame end: start the next frame from zero
    if (ctl.emit) begin
      acc_left_nxt  = '0;
      acc_right_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    tgt_r  <= tgt_nxt;
    e_r    <= e_nxt;
    amp_r  <= amp_nxt;
    s_r    <= s_nxt;
    c_r    <= c_nxt;
    sn_r   <= sn_nxt;
    cn_r   <= cn_nxt;
    samp_r <= samp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_left_r  <= '0;
      acc_right_r <= '0;
    end else begin
      acc_left_r  <= acc_left_nxt;
      acc_right_r <= acc_right_nxt;
    end
  end

  // ---------------------------------------------------------- result register
  // Emit only fires when the register is empty or being taken this cycle.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (ctl.emit) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.sum_left  = sat32(acc_left_r);
      out_data_nxt.sum_right = sat32(acc_right_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: design/qob_mul.sv
// ============================================================================
// qob_mul: shared signed multiplier
// One 27 x 27 signed product per cycle, registered at the output.
// ============================================================================
module qob_mul (
  input  logic                                clk,
  input  logic signed [qob_pkg::OP_W-1:0]     op_a,
  input  logic signed [qob_pkg::OP_W-1:0]     op_b,
  output logic signed [qob_pkg::PROD_W-1:0]   prod_r
);
  import qob_pkg::*;

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

FILE: design/qob_store.sv
// ============================================================================
// qob_store: oscillator state memory
// Sine, cosine and amplitude per partial; one write and one registered read
// port. Entries never written read back as the reset oscillator.
// ============================================================================
module qob_store #(
  parameter int DEPTH = qob_pkg::MAX_PARTIALS_DEF,
  parameter int IDX_W = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  qob_pkg::osc_t     wr_data,
  output qob_pkg::osc_t     rd_data
);
  import qob_pkg::*;

  osc_t             mem_r [DEPTH];
  osc_t             rd_q_r;
  logic [DEPTH-1:0] valid_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem_r[rd_addr];
    end
  end

  // mark written entries
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : OSC_RST;

endmodule

FILE: design/qob_ctrl.sv
// ============================================================================
// qob_ctrl: partial sequencer
// Steps the shared multiplier through the eight products of one partial and
// schedules write-back and frame output.
// ============================================================================
module qob_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_cmd,
  input  logic          in_last,
  input  logic          in_range,
  input  logic          item_last,
  input  logic          out_valid,
  input  logic          out_stall,
  output qob_pkg::ctl_t ctl
);
  import qob_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_cmd == CMD_PROC) begin
          if (in_range) begin
            state_nxt = ST_TGT;
          end else if (in_last) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_TGT:    state_nxt = ST_STEP;
      ST_STEP:   state_nxt = ST_SMOOTH;
      ST_SMOOTH: state_nxt = ST_SIN;
      ST_SIN:    state_nxt = ST_SAMP;
      ST_SAMP:   state_nxt = ST_COS;
      ST_COS:    state_nxt = ST_PANL;
      ST_PANL:   state_nxt = ST_PANR;
      ST_PANR:   state_nxt = ST_DONE;
      ST_DONE:   state_nxt = item_last ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.busy    = 1'b1;
    ctl.mul_op  = MUL_NONE;
    ctl.post_op = POST_NONE;
    ctl.capture = 1'b0;
    ctl.wr_back = 1'b0;
    ctl.emit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.busy = 1'b0;
      end
      ST_TGT: begin
        ctl.capture = 1'b1;
        ctl.mul_op  = MUL_TGT;
      end
      ST_STEP: begin
        ctl.mul_op  = MUL_STEP;
        ctl.post_op = POST_TGT;
      end
      ST_SMOOTH: begin
        ctl.mul_op  = MUL_SMOOTH;
        ctl.post_op = POST_STEP;
      end
      ST_SIN: begin
        ctl.mul_op  = MUL_SIN;
        ctl.post_op = POST_SMOOTH;
      end
      ST_SAMP: begin
        ctl.mul_op  = MUL_SAMP;
        ctl.post_op = POST_SIN;
      end
      ST_COS: begin
        ctl.mul_op  = MUL_COS;
        ctl.post_op = POST_SAMP;
      end
      ST_PANL: begin
        ctl.mul_op  = MUL_PANL;
        ctl.post_op = POST_COS;
      end
      ST_PANR: begin
        ctl.mul_op  = MUL_PANR;
        ctl.post_op = POST_PANL;
      end
      ST_DONE: begin
        ctl.post_op = POST_PANR;
        ctl.wr_back = 1'b1;
      end
      ST_EMIT: begin
        ctl.emit = out_free;
      end
      default: begin
        ctl.busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: design/qob_checker.sv
// ============================================================================
// qob_checker: port-level checks for the oscillator bank
// Watches request and result channels over time; bound to the top level.
// ============================================================================
module qob_checker #(
  parameter int MAX_PARTIALS = qob_pkg::MAX_PARTIALS_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input qob_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input qob_pkg::out_item_t out_data
);
  import qob_pkg::*;

  logic in_take;
  logic proc_in_range;

  assign in_take       = in_valid && !in_stall;
  assign proc_in_range = in_data.cmd == CMD_PROC && 32'(in_data.partial) < MAX_PARTIALS;

  // reset leaves the block idle with no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // a load request leaves the block ready for the next request
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && in_data.cmd == CMD_LOAD |=> !in_stall)
    else $error("load request left the block busy");

  // a process request for a valid partial occupies the sequencer
  a_proc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_take && proc_in_range |=> in_stall)
    else $error("process request did not start the sequence");

  // a new result only appears out of a busy cycle
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without a frame end");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind quadrature_oscillator_bank_top qob_checker #(
  .MAX_PARTIALS (MAX_PARTIALS)
) u_qob_checker (.*);
